>>> hw/rtl/tsed_pkg.sv
// ----------------------------------------------------------------------------
// tsed_pkg
// Shared types and constants for the tag strip and entity decode block.
// ----------------------------------------------------------------------------
package tsed_pkg;

  // Most output bytes that one input transaction can release
  localparam int unsigned TSED_MAX_OUT = 6;

  // Work descriptor handed from the front end to the back end
  typedef struct packed {
    logic [TSED_MAX_OUT-1:0][7:0] bytes;    // output bytes, entry 0 first
    logic [2:0]                   count;    // number of results, 1..6
    logic                         has_byte; // 0 for a bare end marker
    logic                         text_end; // last result closes the unit
  } tsed_job_t;

  localparam int unsigned TSED_JOB_W = $bits(tsed_job_t);

endpackage

>>> hw/rtl/tsed_fifo.sv
// ----------------------------------------------------------------------------
// tsed_fifo
// Small register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module tsed_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("tsed_fifo: push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("tsed_fifo: pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("tsed_fifo: occupancy beyond depth");

endmodule

>>> hw/rtl/tsed_front.sv
// ----------------------------------------------------------------------------
// tsed_front
// Scanner: accepts input bytes, tracks tag/entity state and builds a job
// descriptor with every output byte that the byte releases.
// ----------------------------------------------------------------------------
module tsed_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] in_byte
  input  logic               s_tlast,   // is_last
  input  logic               full,
  output logic               push,
  output tsed_pkg::tsed_job_t job
);
  import tsed_pkg::*;

  typedef enum logic [1:0] {
    MODE_PLAIN,
    MODE_TAG,
    MODE_ENTITY,
    MODE_ENDED
  } mode_t;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [2:0] PFX_MAX  = 3'd4;
  localparam logic [2:0] BRK_LEN  = 3'd4;
  localparam logic [2:0] OUT_MAX  = 3'(TSED_MAX_OUT);

  typedef struct packed {
    logic       full_hit;
    logic       partial;
    logic [1:0] which;
  } cls_t;

  mode_t          mode;
  logic [2:0]     brk_pos;
  logic           brk_ok;
  logic [3:0][7:0] pfx;
  logic [2:0]     pfx_cnt;

  mode_t          mode_next;
  logic [2:0]     brk_pos_next;
  logic           brk_ok_next;
  logic [3:0][7:0] pfx_next;
  logic [2:0]     pfx_cnt_next;
  tsed_job_t      job_next;
  logic [2:0]     n;
  logic           do_plain;
  cls_t           cls;
  logic           accept;

  function automatic logic [7:0] fold(input logic [7:0] c);
    fold = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic [7:0] brk_char(input logic [1:0] i);
    case (i)
      2'd0:    brk_char = CH_LT;
      2'd1:    brk_char = 8'h62;
      2'd2:    brk_char = 8'h72;
      default: brk_char = 8'h2F;
    endcase
  endfunction

  function automatic logic [2:0] ent_len(input logic [1:0] k);
    case (k)
      2'd0:    ent_len = 3'd3;
      2'd1:    ent_len = 3'd3;
      2'd2:    ent_len = 3'd4;
      default: ent_len = 3'd5;
    endcase
  endfunction

  function automatic logic [7:0] ent_char(input logic [1:0] k);
    case (k)
      2'd0:    ent_char = CH_LT;
      2'd1:    ent_char = CH_GT;
      2'd2:    ent_char = CH_AMP;
      default: ent_char = CH_QUOTE;
    endcase
  endfunction

  // Letters of lt; gt; amp; quot;
  function automatic logic [7:0] ent_name(input logic [1:0] k, input logic [2:0] i);
    case ({k, i})
      {2'd0, 3'd0}: ent_name = 8'h6C;
      {2'd0, 3'd1}: ent_name = 8'h74;
      {2'd0, 3'd2}: ent_name = CH_SEMI;
      {2'd1, 3'd0}: ent_name = 8'h67;
      {2'd1, 3'd1}: ent_name = 8'h74;
      {2'd1, 3'd2}: ent_name = CH_SEMI;
      {2'd2, 3'd0}: ent_name = 8'h61;
      {2'd2, 3'd1}: ent_name = 8'h6D;
      {2'd2, 3'd2}: ent_name = 8'h70;
      {2'd2, 3'd3}: ent_name = CH_SEMI;
      {2'd3, 3'd0}: ent_name = 8'h71;
      {2'd3, 3'd1}: ent_name = 8'h75;
      {2'd3, 3'd2}: ent_name = 8'h6F;
      {2'd3, 3'd3}: ent_name = 8'h74;
      {2'd3, 3'd4}: ent_name = CH_SEMI;
      default:      ent_name = 8'h00;
    endcase
  endfunction

  // Match held letters plus this byte against every entity name
  function automatic cls_t classify(input logic [7:0] b, input logic [2:0] cnt,
                                    input logic [3:0][7:0] held);
    cls_t r;
    logic ok;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      ok = (cnt < ent_len(2'(k)));
      for (int i = 0; i < 4; i++) begin
        if (3'(i) < cnt && fold(held[i]) != ent_name(2'(k), 3'(i))) begin
          ok = 1'b0;
        end
      end
      if (fold(b) != ent_name(2'(k), cnt)) begin
        ok = 1'b0;
      end
      if (ok && (cnt + 3'd1 == ent_len(2'(k)))) begin
        if (!r.full_hit) begin
          r.full_hit = 1'b1;
          r.which    = 2'(k);
        end
      end else if (ok) begin
        r.partial = 1'b1;
      end
    end
    classify = r;
  endfunction

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;
  assign cls      = classify(s_tdata, pfx_cnt, pfx);

  // Next state and job contents for the byte on the input
  always_comb begin
    mode_next    = mode;
    brk_pos_next = brk_pos;
    brk_ok_next  = brk_ok;
    pfx_next     = pfx;
    pfx_cnt_next = pfx_cnt;
    job_next     = '0;
    job_next.has_byte = 1'b1;
    n            = 3'd0;
    do_plain     = 1'b0;

    case (mode)
      MODE_PLAIN: begin
        do_plain = 1'b1;
      end
      MODE_TAG: begin
        if (s_tdata == 8'h00) begin
          mode_next = MODE_ENDED;
        end else if (s_tdata == CH_GT) begin
          if (brk_ok && brk_pos == BRK_LEN) begin
            job_next.bytes[n] = CH_NL;
            n = n + 3'd1;
          end
          mode_next    = MODE_PLAIN;
          brk_pos_next = 3'd0;
          brk_ok_next  = 1'b0;
        end else if (brk_ok && brk_pos < BRK_LEN &&
                     fold(s_tdata) == brk_char(brk_pos[1:0])) begin
          brk_pos_next = brk_pos + 3'd1;
        end else begin
          brk_ok_next = 1'b0;
        end
      end
      MODE_ENTITY: begin
        if (cls.full_hit) begin
          job_next.bytes[n] = ent_char(cls.which);
          n = n + 3'd1;
          pfx_cnt_next = 3'd0;
          mode_next    = MODE_PLAIN;
        end else if (cls.partial && pfx_cnt < PFX_MAX) begin
          pfx_next[pfx_cnt[1:0]] = s_tdata;
          pfx_cnt_next = pfx_cnt + 3'd1;
        end else begin
          // Broken entity: release '&' and the held letters
          job_next.bytes[n] = CH_AMP;
          n = n + 3'd1;
          for (int i = 0; i < 4; i++) begin
            if (3'(i) < pfx_cnt && n < OUT_MAX) begin
              job_next.bytes[n] = pfx[i];
              n = n + 3'd1;
            end
          end
          pfx_cnt_next = 3'd0;
          mode_next    = MODE_PLAIN;
          do_plain     = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Handle the byte as plain text
    if (do_plain) begin
      if (s_tdata == 8'h00) begin
        mode_next = MODE_ENDED;
      end else if (s_tdata == CH_LT) begin
        mode_next    = MODE_TAG;
        brk_pos_next = 3'd1;
        brk_ok_next  = 1'b1;
      end else if (s_tdata == CH_AMP) begin
        mode_next    = MODE_ENTITY;
        pfx_cnt_next = 3'd0;
      end else if (n < OUT_MAX) begin
        job_next.bytes[n] = s_tdata;
        n = n + 3'd1;
      end
    end

    // Close the unit: flush a held prefix, mark the end, clear state
    if (s_tlast) begin
      if (mode_next == MODE_ENTITY) begin
        if (n < OUT_MAX) begin
          job_next.bytes[n] = CH_AMP;
          n = n + 3'd1;
        end
        for (int i = 0; i < 4; i++) begin
          if (3'(i) < pfx_cnt_next && n < OUT_MAX) begin
            job_next.bytes[n] = pfx_next[i];
            n = n + 3'd1;
          end
        end
      end
      if (n == 3'd0) begin
        job_next.has_byte = 1'b0;
        n = 3'd1;
      end
      job_next.text_end = 1'b1;
      mode_next    = MODE_PLAIN;
      brk_pos_next = 3'd0;
      brk_ok_next  = 1'b0;
      pfx_cnt_next = 3'd0;
    end

    job_next.count = n;
  end

  assign push = accept && (n != 3'd0);
  assign job  = job_next;

  // Hold scan state; advance on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_PLAIN;
      brk_pos <= 3'd0;
      brk_ok  <= 1'b0;
      pfx_cnt <= 3'd0;
    end else if (accept) begin
      mode    <= mode_next;
      brk_pos <= brk_pos_next;
      brk_ok  <= brk_ok_next;
      pfx_cnt <= pfx_cnt_next;
    end
  end

  // Held entity letters carry no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      pfx <= pfx_next;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) pfx_cnt <= PFX_MAX)
    else $error("tsed_front: prefix count out of range");
  a_last_pushes: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |-> (push && job.text_end))
    else $error("tsed_front: end of unit gave no job");
  a_prefix_mode: assert property (@(posedge clk) disable iff (rst)
    (pfx_cnt != 3'd0) |-> (mode == MODE_ENTITY))
    else $error("tsed_front: letters held outside an entity");

endmodule

>>> hw/rtl/tsed_back.sv
// ----------------------------------------------------------------------------
// tsed_back
// Emitter: walks the job at the queue head and releases one result per cycle
// while the receiver is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module tsed_back (
  input  logic                clk,
  input  logic                rst,
  input  tsed_pkg::tsed_job_t head,
  input  logic                empty,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,  // [7:0] out_byte
  output logic                m_tlast,  // run_end
  output logic [1:0]          m_tuser   // [0] has_byte, [1] text_end
);
  import tsed_pkg::*;

  logic [2:0] idx;
  logic       load;
  logic       job_done;

  assign load     = !empty && (!m_tvalid || m_tready);
  assign job_done = (idx == head.count - 3'd1);
  assign pop      = load && job_done;

  // Step through the head job
  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= 3'd0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        idx      <= job_done ? 3'd0 : idx + 3'd1;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata    <= head.bytes[idx];
      m_tlast    <= job_done;
      m_tuser[0] <= head.has_byte;
      m_tuser[1] <= head.text_end && job_done;
    end
  end

  a_text_end_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> m_tlast)
    else $error("tsed_back: text end not on the last result of a run");
  a_marker_alone: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tlast && m_tuser[1] && m_tdata == 8'h00))
    else $error("tsed_back: bare marker malformed");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (head.count != 3'd0 && idx < head.count))
    else $error("tsed_back: index beyond job");

endmodule

>>> hw/rtl/tag_strip_entity_decode_core.sv
// ----------------------------------------------------------------------------
// tag_strip_entity_decode_core
// Subtitle text to plain text: drops tags, turns <br/> into a newline and
// decodes the &lt; &gt; &amp; &quot; entities.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one text byte per transaction in s_tdata, s_tlast marks
//   the final byte of a subtitle unit. A zero byte ends the text; later bytes
//   of the unit are swallowed.
//   Output stream m_*: one plain-text byte per transaction. m_tlast marks the
//   last result caused by one input byte, m_tuser[1] marks the final result
//   of the unit, and m_tuser[0] is low for a bare end marker (m_tdata zero).
//   Results of an accepted byte pass through the job queue and then the
//   output register.
//   Throughput: the scanner accepts one byte per cycle while the job queue
//   has room; the emitter gives one result per cycle while the receiver is
//   ready, releasing the results of one input byte (up to six for a broken
//   entity) in order. The single output register sets the one-result-per-cycle
//   figure.
//   Reset clears scan state, the queue and the output valid flag; no clearing
//   pass is needed. When the receiver stalls, the output holds, the queue
//   fills, and s_tready drops once QUEUE_DEPTH jobs wait.
// ----------------------------------------------------------------------------
module tag_strip_entity_decode_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // is_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,   // run_end
  output logic [1:0] m_tuser    // [0] has_byte, [1] text_end
);
  import tsed_pkg::*;

  tsed_job_t wr_job;
  tsed_job_t head;
  logic      push;
  logic      pop;
  logic      full;
  logic      empty;

  // Scanner
  tsed_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .full     (full),
    .push     (push),
    .job      (wr_job)
  );

  // Job queue
  tsed_fifo #(
    .WIDTH (TSED_JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_job),
    .pop     (pop),
    .rd_data (head),
    .full    (full),
    .empty   (empty)
  );

  // Emitter
  tsed_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
